FILE: rtl/vmsf_pkg.sv
// ----------------------------------------------------------------------------
// vmsf_pkg
// Shared types, register map and constants for the vehicle mode and safety
// state machine.
// ----------------------------------------------------------------------------
package vmsf_pkg;

  // Configuration port geometry
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_ROLL_LIMIT   = 3'd0;
  localparam logic [2:0] REG_ECO_LIMIT    = 3'd1;
  localparam logic [2:0] REG_NORMAL_LIMIT = 3'd2;
  localparam logic [2:0] REG_SPORT_LIMIT  = 3'd3;
  localparam logic [2:0] REG_ODO_START    = 3'd4;
  localparam logic [2:0] REG_SAVE_STEP    = 3'd5;

  // Register reset values
  localparam logic [10:0] ROLL_LIMIT_RST   = 11'd450;
  localparam logic [7:0]  ECO_LIMIT_RST    = 8'd25;
  localparam logic [7:0]  NORMAL_LIMIT_RST = 8'd60;
  localparam logic [7:0]  SPORT_LIMIT_RST  = 8'd85;
  localparam logic [31:0] ODO_START_RST    = 32'd0;
  localparam logic [15:0] SAVE_STEP_RST    = 16'd1000;

  // Machine state codes as shown on the result channel
  localparam logic [1:0] ST_INIT    = 2'd0;
  localparam logic [1:0] ST_STANDBY = 2'd1;
  localparam logic [1:0] ST_DRIVING = 2'd2;
  localparam logic [1:0] ST_FAULT   = 2'd3;

  // Drive mode codes
  localparam logic [1:0] DRIVE_ECO    = 2'd0;
  localparam logic [1:0] DRIVE_NORMAL = 2'd1;
  localparam logic [1:0] DRIVE_SPORT  = 2'd2;

  // Gear codes
  localparam logic [1:0] GEAR_NEUTRAL = 2'd0;
  localparam logic [1:0] GEAR_ECO     = 2'd1;
  localparam logic [1:0] GEAR_NORMAL  = 2'd2;
  localparam logic [1:0] GEAR_SPORT   = 2'd3;

  // Battery simulation
  localparam logic [6:0] BATT_FULL   = 7'd100;
  localparam logic [3:0] BATT_PERIOD = 4'd10;

  // Odometer: each tick adds 5*|rpm| sixths of a metre
  localparam logic [2:0]  SIXTHS_PER_M = 3'd6;
  // ceil(2^20 / 6): exact floor divide by 6 for dividends below 2^19
  localparam logic [17:0] DIV6_RECIP   = 18'd174763;
  localparam int          DIV6_SHIFT   = 20;
  // ceil(2^19 / 100): exact floor divide by 100 for dividends below 43690
  localparam logic [12:0] DIV100_RECIP = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  localparam logic [7:0]  SPEED_MAX    = 8'd255;

  // Odometer step result
  typedef struct packed {
    logic        save;
    logic [31:0] metres;
  } odo_res_t;

endpackage

FILE: rtl/vmsf_in_if.sv
// ----------------------------------------------------------------------------
// vmsf_in_if
// Tick channel: one transaction carries one 50 ms sensor sample.
// ----------------------------------------------------------------------------
interface vmsf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] wheel_rpm;
  logic signed [11:0] roll_angle;
  logic [6:0]         throttle;
  logic [1:0]         drive_mode;
  logic               run_enable;

  modport source (
    output valid, wheel_rpm, roll_angle, throttle, drive_mode, run_enable,
    input  ready
  );

  modport sink (
    input  valid, wheel_rpm, roll_angle, throttle, drive_mode, run_enable,
    output ready
  );
endinterface

FILE: rtl/vmsf_out_if.sv
// ----------------------------------------------------------------------------
// vmsf_out_if
// Result channel: one transaction per accepted tick.
// ----------------------------------------------------------------------------
interface vmsf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  target_speed;
  logic [6:0]  battery_level;
  logic [1:0]  gear_shown;
  logic [1:0]  machine_state;
  logic        motor_cut;
  logic        save_request;
  logic [31:0] saved_metres;

  modport source (
    output valid, target_speed, battery_level, gear_shown, machine_state,
           motor_cut, save_request, saved_metres,
    input  ready
  );

  modport sink (
    input  valid, target_speed, battery_level, gear_shown, machine_state,
           motor_cut, save_request, saved_metres,
    output ready
  );
endinterface

FILE: rtl/vmsf_odo.sv
// ----------------------------------------------------------------------------
// vmsf_odo
// Odometer in whole metres plus a sixths remainder, with saturation at the
// 32-bit metre limit and the save-request check against the last saved value.
// ----------------------------------------------------------------------------
module vmsf_odo
  import vmsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,        // commit one tick
  input  logic [14:0] add_metres,  // whole metres of this tick's distance
  input  logic [2:0]  add_sixths,  // leftover sixths of this tick's distance
  input  logic        load,        // reseed from the start register
  input  logic [31:0] start_metres,
  input  logic [15:0] save_step,
  output odo_res_t    res
);

  logic [31:0] metres_r, metres_nxt;
  logic [2:0]  rem_r, rem_nxt;
  logic [31:0] last_r, last_nxt;

  logic [3:0]  rem_sum;
  logic        carry;
  logic [2:0]  rem_wrap;
  logic [32:0] m_sum;
  logic        sat;
  logic [31:0] diff;
  logic        save;

  // Remainder carry, then metre sum with saturation
  always_comb begin
    rem_sum  = {1'b0, rem_r} + {1'b0, add_sixths};
    carry    = (rem_sum >= {1'b0, SIXTHS_PER_M});
    rem_wrap = carry ? 3'(rem_sum - {1'b0, SIXTHS_PER_M}) : rem_sum[2:0];
    m_sum    = {1'b0, metres_r} + {18'd0, add_metres} + {32'd0, carry};
    sat      = (m_sum >= {1'b0, 32'hFFFF_FFFF});
    metres_nxt = sat ? 32'hFFFF_FFFF : m_sum[31:0];
    rem_nxt    = sat ? 3'd0 : rem_wrap;
  end

  // Save check on the updated metres
  always_comb begin
    diff       = metres_nxt - last_r;
    save       = (metres_nxt >= last_r) && (diff >= {16'd0, save_step});
    last_nxt   = save ? metres_nxt : last_r;
    res.save   = save;
    res.metres = save ? metres_nxt : 32'd0;
  end

  // Odometer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metres_r <= ODO_START_RST;
      rem_r    <= 3'd0;
      last_r   <= ODO_START_RST;
    end else if (load) begin
      metres_r <= start_metres;
      rem_r    <= 3'd0;
      last_r   <= start_metres;
    end else if (step) begin
      metres_r <= metres_nxt;
      rem_r    <= rem_nxt;
      last_r   <= last_nxt;
    end
  end

endmodule

FILE: rtl/vehicle_mode_safety_fsm_unit.sv
// ----------------------------------------------------------------------------
// vehicle_mode_safety_fsm_unit
// Per-tick odometer, simulated battery and drive mode / crash state machine.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one transaction per 50 ms tick (rpm, roll, throttle, mode,
//            run enable), accepted when valid and ready are both high.
//   out_ch : exactly one result transaction per accepted tick, in order.
//   APB    : six configuration registers at byte addresses 4*i; writes land
//            when psel, penable, pwrite and pready are high, pready is tied
//            high. Writing the odometer start reseeds the odometer and the
//            last saved value. Write only while no tick is in flight.
// Timing:
//   Two register stages: the input stage holds the distance split into
//   metres and sixths and the throttle-limit product, the result stage
//   holds the state update. The result is registered in the result stage
//   after the tick leaves the input stage; one tick per cycle is sustained
//   while out_ch.ready is high; odometer and state update once per result.
// Reset (rst_n, synchronous): registers to their defaults, state INIT,
//   battery 100, both stages empty.
// Stall: while out_ch.ready is low the result holds; one further tick may
//   be taken into the input stage, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module vehicle_mode_safety_fsm_unit
  import vmsf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  vmsf_in_if.sink           in_ch,
  vmsf_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  typedef enum logic [1:0] {
    S_INIT    = ST_INIT,
    S_STANDBY = ST_STANDBY,
    S_DRIVING = ST_DRIVING,
    S_FAULT   = ST_FAULT
  } fsm_state_t;

  // Configuration registers
  logic [10:0] roll_limit_r;
  logic [7:0]  eco_lim_r, normal_lim_r, sport_lim_r;
  logic [31:0] odo_start_r;
  logic [15:0] save_step_r;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  // Handshake control
  logic        s1_valid_r, out_valid_r;
  logic        out_take, s1_adv, in_acc;

  // Input stage
  logic [15:0] rpm_abs;
  logic [17:0] dist5;
  logic [35:0] div6_prod;
  logic [14:0] q6;
  logic [17:0] q6_times6;
  logic [2:0]  r6;
  logic [7:0]  lim_sel;
  logic [14:0] speed_prod;
  logic [11:0] roll_abs;

  logic [14:0] q6_r;
  logic [2:0]  r6_r;
  logic [14:0] speed_prod_r;
  logic [11:0] roll_abs_r;
  logic [1:0]  mode_r;
  logic        enable_r;

  // Result stage
  fsm_state_t  state_r, state_nxt;
  logic [7:0]  speed_r, speed_nxt;
  logic [1:0]  gear_r, gear_nxt;
  logic [6:0]  batt_r, batt_nxt;
  logic [3:0]  ticks_r, ticks_nxt;
  logic        cut_r, cut_nxt;
  logic        save_r;
  logic [31:0] saved_r;

  logic [27:0] div100_prod;
  logic [8:0]  speed_raw;
  logic [7:0]  speed_drive;
  logic [1:0]  gear_drive;
  logic        crash;
  logic [3:0]  ticks_inc;
  logic [6:0]  batt_dec;
  odo_res_t    odo_res;

  // --------------------------------------------------------------------------
  // APB configuration
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_limit_r <= ROLL_LIMIT_RST;
      eco_lim_r    <= ECO_LIMIT_RST;
      normal_lim_r <= NORMAL_LIMIT_RST;
      sport_lim_r  <= SPORT_LIMIT_RST;
      odo_start_r  <= ODO_START_RST;
      save_step_r  <= SAVE_STEP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ROLL_LIMIT:   roll_limit_r <= pwdata[10:0];
        REG_ECO_LIMIT:    eco_lim_r    <= pwdata[7:0];
        REG_NORMAL_LIMIT: normal_lim_r <= pwdata[7:0];
        REG_SPORT_LIMIT:  sport_lim_r  <= pwdata[7:0];
        REG_ODO_START:    odo_start_r  <= pwdata;
        REG_SAVE_STEP:    save_step_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (cfg_idx)
      REG_ROLL_LIMIT:   prdata = {21'd0, roll_limit_r};
      REG_ECO_LIMIT:    prdata = {24'd0, eco_lim_r};
      REG_NORMAL_LIMIT: prdata = {24'd0, normal_lim_r};
      REG_SPORT_LIMIT:  prdata = {24'd0, sport_lim_r};
      REG_ODO_START:    prdata = odo_start_r;
      REG_SAVE_STEP:    prdata = {16'd0, save_step_r};
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Flow control: two-stage pipeline, each stage moves when the next frees
  // --------------------------------------------------------------------------
  assign out_take    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_take;
  assign in_ch.ready = !s1_valid_r || out_take;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc)      s1_valid_r <= 1'b1;
      else if (s1_adv) s1_valid_r <= 1'b0;

      if (s1_adv)            out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Input stage: absolute values, distance split into metres and sixths,
  // throttle times the selected mode limit
  // --------------------------------------------------------------------------
  always_comb begin
    rpm_abs   = in_ch.wheel_rpm[15] ? 16'(-in_ch.wheel_rpm) : in_ch.wheel_rpm;
    roll_abs  = in_ch.roll_angle[11] ? 12'(-in_ch.roll_angle) : in_ch.roll_angle;
    dist5     = {rpm_abs, 2'b00} + {2'b00, rpm_abs};
    div6_prod = 36'(dist5) * 36'(DIV6_RECIP);
    q6        = div6_prod[DIV6_SHIFT +: 15];
    q6_times6 = {2'b00, q6, 1'b0} + {1'b0, q6, 2'b00};
    r6        = 3'(dist5 - q6_times6);

    case (in_ch.drive_mode)
      DRIVE_ECO:   lim_sel = eco_lim_r;
      DRIVE_SPORT: lim_sel = sport_lim_r;
      default:     lim_sel = normal_lim_r;
    endcase
    speed_prod = 15'(in_ch.throttle) * 15'(lim_sel);
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      q6_r         <= q6;
      r6_r         <= r6;
      speed_prod_r <= speed_prod;
      roll_abs_r   <= roll_abs;
      mode_r       <= in_ch.drive_mode;
      enable_r     <= in_ch.run_enable;
    end
  end

  // --------------------------------------------------------------------------
  // Odometer and save request
  // --------------------------------------------------------------------------
  vmsf_odo u_odo (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (s1_adv),
    .add_metres   (q6_r),
    .add_sixths   (r6_r),
    .load         (cfg_wr && (cfg_idx == REG_ODO_START)),
    .start_metres (pwdata),
    .save_step    (save_step_r),
    .res          (odo_res)
  );

  // --------------------------------------------------------------------------
  // Result stage: speed, battery, crash check and state machine
  // --------------------------------------------------------------------------
  always_comb begin
    // speed = throttle * limit / 100, saturated
    div100_prod = 28'(speed_prod_r) * 28'(DIV100_RECIP);
    speed_raw   = div100_prod[DIV100_SHIFT +: 9];
    speed_drive = speed_raw[8] ? SPEED_MAX : speed_raw[7:0];

    case (mode_r)
      DRIVE_ECO:   gear_drive = GEAR_ECO;
      DRIVE_SPORT: gear_drive = GEAR_SPORT;
      default:     gear_drive = GEAR_NORMAL;
    endcase

    // battery drops once every eleven ticks, empty wraps to full
    ticks_inc = ticks_r + 4'd1;
    batt_dec  = batt_r - 7'd1;
    if (ticks_inc > BATT_PERIOD) begin
      ticks_nxt = 4'd0;
      batt_nxt  = (batt_dec == 7'd0) ? BATT_FULL : batt_dec;
    end else begin
      ticks_nxt = ticks_inc;
      batt_nxt  = batt_r;
    end

    crash = ((state_r == S_STANDBY) || (state_r == S_DRIVING)) &&
            ({1'b0, roll_abs_r} > {2'b00, roll_limit_r});

    state_nxt = state_r;
    speed_nxt = speed_r;
    gear_nxt  = gear_r;
    cut_nxt   = crash;
    if (crash) begin
      state_nxt = S_FAULT;
      speed_nxt = 8'd0;
      gear_nxt  = GEAR_NEUTRAL;
    end else begin
      unique case (state_r)
        S_INIT: state_nxt = S_STANDBY;
        S_STANDBY: begin
          speed_nxt = 8'd0;
          if (enable_r) state_nxt = S_DRIVING;
        end
        S_DRIVING: begin
          speed_nxt = speed_drive;
          gear_nxt  = gear_drive;
          if (!enable_r) state_nxt = S_STANDBY;
        end
        S_FAULT: begin
          speed_nxt = 8'd0;
          gear_nxt  = GEAR_NEUTRAL;
        end
        default: state_nxt = S_INIT;
      endcase
    end
  end

  // State and registered outputs, updated once per tick leaving the pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      speed_r <= 8'd0;
      gear_r  <= GEAR_NEUTRAL;
      batt_r  <= BATT_FULL;
      ticks_r <= 4'd0;
      cut_r   <= 1'b0;
      save_r  <= 1'b0;
      saved_r <= 32'd0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
      speed_r <= speed_nxt;
      gear_r  <= gear_nxt;
      batt_r  <= batt_nxt;
      ticks_r <= ticks_nxt;
      cut_r   <= cut_nxt;
      save_r  <= odo_res.save;
      saved_r <= odo_res.metres;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.target_speed  = speed_r;
  assign out_ch.battery_level = batt_r;
  assign out_ch.gear_shown    = gear_r;
  assign out_ch.machine_state = state_r;
  assign out_ch.motor_cut     = cut_r;
  assign out_ch.save_request  = save_r;
  assign out_ch.saved_metres  = saved_r;

endmodule

FILE: rtl/vmsf_checker.sv
// ----------------------------------------------------------------------------
// vmsf_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module vmsf_checker
  import vmsf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  target_speed,
  input logic [1:0]  gear_shown,
  input logic [1:0]  machine_state,
  input logic        motor_cut,
  input logic        save_request,
  input logic [31:0] saved_metres
);

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(saved_metres) &&
      $stable(machine_state) && $stable(target_speed))
    else $error("result changed while stalled");

  // The first tick always leaves INIT, so INIT is never reported
  a_no_init: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> machine_state != ST_INIT)
    else $error("INIT state reported");

  // A crash result shows FAULT with the motor stopped
  a_cut_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && motor_cut |->
      machine_state == ST_FAULT && target_speed == 8'd0 &&
      gear_shown == GEAR_NEUTRAL)
    else $error("motor cut without fault");

  // Saved metres are zero unless a save is requested
  a_save_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !save_request |-> saved_metres == 32'd0)
    else $error("saved metres without save request");

  // The latched fault always shows a stopped motor in neutral
  a_fault_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && machine_state == ST_FAULT |->
      target_speed == 8'd0 && gear_shown == GEAR_NEUTRAL)
    else $error("fault with motor running");

endmodule

bind vehicle_mode_safety_fsm_unit vmsf_checker u_vmsf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .target_speed  (out_ch.target_speed),
  .gear_shown    (out_ch.gear_shown),
  .machine_state (out_ch.machine_state),
  .motor_cut     (out_ch.motor_cut),
  .save_request  (out_ch.save_request),
  .saved_metres  (out_ch.saved_metres)
);
